// ----- sv/complex_number_alu_macros.svh -----
// assertion helpers for the complex number alu
`ifndef COMPLEX_NUMBER_ALU_MACROS_SVH
`define COMPLEX_NUMBER_ALU_MACROS_SVH

`ifndef ASSERT_OFF
// checked on every rising clock edge, switched off while reset is applied
`define CNA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("complex_number_alu check failed");
// checked on every rising clock edge, reset included
`define CNA_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("complex_number_alu check failed");
`else
`define CNA_ASSERT(lbl, prop)
`define CNA_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- sv/cna_pkg.sv -----
package cna_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DW        = 32;
	localparam int PW        = 2 * DW;
	localparam int SAT_W     = PW - FRAC_BITS + 1;
	localparam int REM_W     = DW + 2;
	localparam int ITERS     = 2;
	localparam int SQ_STAGES = (PW / 2) / ITERS;

	localparam logic [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};

	typedef enum logic [2:0] {
		MODE_ADD  = 3'd0,
		MODE_SUB  = 3'd1,
		MODE_MUL  = 3'd2,
		MODE_MOD  = 3'd3,
		MODE_CONJ = 3'd4
	} mode_t;

	// result of the non-root modes, carried alongside the root pipeline
	typedef struct packed {
		logic          is_mod;
		logic [DW-1:0] re;
		logic [DW-1:0] im;
		logic          ovf;
	} side_t;

	typedef struct packed {
		logic [PW-1:0]    rad;
		logic [REM_W-1:0] rem;
		logic [DW-1:0]    root;
		side_t            side;
	} sq_t;

	typedef struct packed {
		logic en;
		logic vld;
	} stg_ctl_t;

endpackage

// ----- sv/cna_sqrt_stage.sv -----
module cna_sqrt_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  cna_pkg::stg_ctl_t ctl,
	input  cna_pkg::sq_t      d,
	output logic              vld,
	output cna_pkg::sq_t      q
);
	import cna_pkg::*;

	logic valid_q;
	sq_t  data_q;
	sq_t  nxt;

	// two restoring square root digits per stage
	always_comb begin
		logic [REM_W+1:0] shifted;
		logic [REM_W+2:0] diff;
		nxt = d;
		for (int i = 0; i < ITERS; i++) begin
			shifted = {nxt.rem, nxt.rad[PW-1 -: 2]};
			diff    = {1'b0, shifted} - {3'b000, nxt.root, 2'b01};
			if (!diff[REM_W+2]) begin
				nxt.rem  = diff[REM_W-1:0];
				nxt.root = {nxt.root[DW-2:0], 1'b1};
			end else begin
				nxt.rem  = shifted[REM_W-1:0];
				nxt.root = {nxt.root[DW-2:0], 1'b0};
			end
			nxt.rad = {nxt.rad[PW-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.en) begin
			valid_q <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			data_q <= nxt;
		end
	end

	assign vld = valid_q;
	assign q   = data_q;

endmodule

// ----- sv/complex_number_alu.sv -----
// complex number alu, signed Q16.16
// input stream s_axis: tuser carries the mode (add, subtract, multiply,
// modulus of a, conjugate of a), tdata the operands a and b. output stream
// m_axis: tdata carries the result, tuser the saturation flag.
// one result leaves for every input transfer, in order.
// pipeline: input register, product register, combine register, 16 square root
// stages with two root digits each, output register, the same for every mode.
// throughput: one transfer per cycle; each stage holds its item until the
// next stage has room, so a stall of the receiver fills the empty stages
// first and the input keeps taking transfers until the pipe is full.
// modes 5 to 7 give an all zero result.
// reset clears every valid bit; items in flight are dropped.
module complex_number_alu (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // a_re, a_im, b_re, b_im
	input  logic [2:0]   s_axis_tuser,  // mode
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata,  // res_re, res_im
	output logic [0:0]   m_axis_tuser   // overflow
);
	import cna_pkg::*;

`include "complex_number_alu_macros.svh"

	// stage 1: input register
	logic                 vld_s1;
	logic [2:0]           mode_s1;
	logic signed [DW-1:0] a_re_s1, a_im_s1, b_re_s1, b_im_s1;
	// stage 2: products and simple results
	logic                 vld_s2;
	logic [2:0]           mode_s2;
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2;
	side_t                side_s2;
	// stage 3: combined results, root input
	logic                 vld_s3;
	sq_t                  sq_s3;
	// output stage
	logic                 vld_s20;
	logic [DW-1:0]        res_re_s20, res_im_s20;
	logic                 ovf_s20, is_mod_s20;

	logic en_s1, en_s2, en_s3, en_out;
	logic [SQ_STAGES-1:0] sq_vld, sq_en;
	sq_t  sq_q [SQ_STAGES];

	function automatic logic [DW:0] sat(input logic signed [SAT_W-1:0] x);
		if (x > $signed(SAT_W'(S_MAX))) begin
			return {1'b1, S_MAX};
		end else if (x < $signed({{(SAT_W-DW){1'b1}}, S_MIN})) begin
			return {1'b1, S_MIN};
		end
		return {1'b0, x[DW-1:0]};
	endfunction

	// a stage moves on when it is empty or the next one moves on
	assign en_out        = !vld_s20 || m_axis_tready;
	assign en_s3         = !vld_s3 || sq_en[0];
	assign en_s2         = !vld_s2 || en_s3;
	assign en_s1         = !vld_s1 || en_s2;
	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s20 <= 1'b0;
		end else begin
			if (en_s1)  vld_s1  <= s_axis_tvalid;
			if (en_s2)  vld_s2  <= vld_s1;
			if (en_s3)  vld_s3  <= vld_s2;
			if (en_out) vld_s20 <= sq_vld[SQ_STAGES-1];
		end
	end

	// stage 1
	always_ff @(posedge clk) begin
		if (en_s1) begin
			mode_s1 <= s_axis_tuser;
			a_re_s1 <= s_axis_tdata[31:0];
			a_im_s1 <= s_axis_tdata[63:32];
			b_re_s1 <= s_axis_tdata[95:64];
			b_im_s1 <= s_axis_tdata[127:96];
		end
	end

	// stage 2: the modulus reuses the first two multipliers for the squares
	logic signed [DW-1:0] m0_b, m1_b;
	logic signed [DW:0]   sum_re, sum_im, neg_im;
	side_t                side_c2;

	always_comb begin
		logic [DW:0] s_re, s_im;
		m0_b   = (mode_s1 == MODE_MOD) ? a_re_s1 : b_re_s1;
		m1_b   = (mode_s1 == MODE_MOD) ? a_im_s1 : b_im_s1;
		sum_re = (mode_s1 == MODE_SUB) ? (DW+1)'(a_re_s1) - (DW+1)'(b_re_s1)
		                               : (DW+1)'(a_re_s1) + (DW+1)'(b_re_s1);
		sum_im = (mode_s1 == MODE_SUB) ? (DW+1)'(a_im_s1) - (DW+1)'(b_im_s1)
		                               : (DW+1)'(a_im_s1) + (DW+1)'(b_im_s1);
		neg_im = -((DW+1)'(a_im_s1));
		s_re   = sat(SAT_W'(sum_re));
		s_im   = sat(SAT_W'(sum_im));
		side_c2 = '0;
		case (mode_s1)
			MODE_ADD, MODE_SUB: begin
				side_c2.re  = s_re[DW-1:0];
				side_c2.im  = s_im[DW-1:0];
				side_c2.ovf = s_re[DW] | s_im[DW];
			end
			MODE_CONJ: begin
				s_im        = sat(SAT_W'(neg_im));
				side_c2.re  = a_re_s1;
				side_c2.im  = s_im[DW-1:0];
				side_c2.ovf = s_im[DW];
			end
			default: begin
				side_c2 = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			mode_s2 <= mode_s1;
			p0_s2   <= PW'(a_re_s1) * PW'(m0_b);
			p1_s2   <= PW'(a_im_s1) * PW'(m1_b);
			p2_s2   <= PW'(a_re_s1) * PW'(b_im_s1);
			p3_s2   <= PW'(a_im_s1) * PW'(b_re_s1);
			side_s2 <= side_c2;
		end
	end

	// stage 3: arithmetic shift of each product rounds toward minus infinity
	sq_t sq_c3;

	always_comb begin
		logic signed [SAT_W-1:0] mre, mim;
		logic [DW:0]             s_re, s_im;
		mre = SAT_W'($signed(p0_s2[PW-1:FRAC_BITS])) - SAT_W'($signed(p1_s2[PW-1:FRAC_BITS]));
		mim = SAT_W'($signed(p2_s2[PW-1:FRAC_BITS])) + SAT_W'($signed(p3_s2[PW-1:FRAC_BITS]));
		s_re = sat(mre);
		s_im = sat(mim);
		sq_c3.rad  = p0_s2 + p1_s2;
		sq_c3.rem  = '0;
		sq_c3.root = '0;
		sq_c3.side = side_s2;
		sq_c3.side.is_mod = (mode_s2 == MODE_MOD);
		if (mode_s2 == MODE_MUL) begin
			sq_c3.side.re  = s_re[DW-1:0];
			sq_c3.side.im  = s_im[DW-1:0];
			sq_c3.side.ovf = s_re[DW] | s_im[DW];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			sq_s3 <= sq_c3;
		end
	end

	// square root pipeline
	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
		stg_ctl_t ctl;
		sq_t      d;
		logic     en_next;
		if (k == 0) begin : g_first
			assign d       = sq_s3;
			assign ctl.vld = vld_s3;
		end else begin : g_rest
			assign d       = sq_q[k-1];
			assign ctl.vld = sq_vld[k-1];
		end
		if (k == SQ_STAGES - 1) begin : g_last
			assign en_next = en_out;
		end else begin : g_mid
			assign en_next = sq_en[k+1];
		end
		assign sq_en[k] = !sq_vld[k] || en_next;
		assign ctl.en   = sq_en[k];
		cna_sqrt_stage u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.d      (d),
			.vld    (sq_vld[k]),
			.q      (sq_q[k])
		);
	end

	// output stage
	sq_t last;
	assign last = sq_q[SQ_STAGES-1];

	always_ff @(posedge clk) begin
		if (en_out) begin
			is_mod_s20 <= last.side.is_mod;
			if (last.side.is_mod) begin
				res_re_s20 <= last.root[DW-1] ? S_MAX : last.root;
				res_im_s20 <= '0;
				ovf_s20    <= last.root[DW-1];
			end else begin
				res_re_s20 <= last.side.re;
				res_im_s20 <= last.side.im;
				ovf_s20    <= last.side.ovf;
			end
		end
	end

	assign m_axis_tvalid   = vld_s20;
	assign m_axis_tdata    = {res_im_s20, res_re_s20};
	assign m_axis_tuser[0] = ovf_s20;

	// some part of the result sits on a saturation bound
	logic at_rail;
	assign at_rail = res_re_s20 == S_MAX || res_re_s20 == S_MIN
		|| res_im_s20 == S_MAX || res_im_s20 == S_MIN;

	`CNA_ASSERT(a_ovf_sat, m_axis_tvalid && ovf_s20 |-> at_rail)
	`CNA_ASSERT(a_mod_im_zero, m_axis_tvalid && is_mod_s20 |-> res_im_s20 == '0)
	`CNA_ASSERT(a_take_lands, s_axis_tvalid && s_axis_tready |=> vld_s1)
	`CNA_ASSERT_ALWAYS(a_room_ready, !vld_s1 |-> s_axis_tready)

endmodule
